[hdl/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants of the charge phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

  // charge phase codes
  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhRise    = 3'd1,
    PhRestart = 3'd2,
    PhCv      = 3'd3,
    PhTaper   = 3'd4,
    PhDepol   = 3'd5,
    PhFull    = 3'd6
  } phase_e;

  // register indexes (byte address is 4 times the index)
  localparam logic [2:0] RegCvVoltage    = 3'd0;
  localparam logic [2:0] RegTaperSoc     = 3'd1;
  localparam logic [2:0] RegTaperVoltage = 3'd2;
  localparam logic [2:0] RegFullCurrent  = 3'd3;
  localparam logic [2:0] RegFullVoltage  = 3'd4;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // commanded current at or below which taper goes to depolarize
  localparam logic [13:0] DepolCurrentMa = 14'd100;

  typedef struct packed {
    logic [12:0] cv_voltage_mv;
    logic [6:0]  taper_soc_pct;
    logic [12:0] taper_voltage_mv;
    logic [13:0] full_current_ma;
    logic [12:0] full_voltage_mv;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         thermal_limit;
    logic [13:0]        commanded_ma;
    logic [6:0]         charge_level_pct;
    logic signed [14:0] battery_ma;
    logic [12:0]        battery_mv;
  } tick_t;

endpackage

`default_nettype wire

[hdl/cps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cps_cfg_regs
// APB register file holding the charge thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cps_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [cps_pkg::DataWidth-1:0]  pwdata,
  output logic      [cps_pkg::DataWidth-1:0]  prdata,
  output logic                                pready,
  output cps_pkg::cfg_t                       cfg_o
);

  cps_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[cps_pkg::AddrWidth-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cps_pkg::RegCvVoltage:    cfg_d.cv_voltage_mv    = pwdata[12:0];
        cps_pkg::RegTaperSoc:     cfg_d.taper_soc_pct    = pwdata[6:0];
        cps_pkg::RegTaperVoltage: cfg_d.taper_voltage_mv = pwdata[12:0];
        cps_pkg::RegFullCurrent:  cfg_d.full_current_ma  = pwdata[13:0];
        cps_pkg::RegFullVoltage:  cfg_d.full_voltage_mv  = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      cps_pkg::RegCvVoltage:    prdata = {19'd0, cfg_q.cv_voltage_mv};
      cps_pkg::RegTaperSoc:     prdata = {25'd0, cfg_q.taper_soc_pct};
      cps_pkg::RegTaperVoltage: prdata = {19'd0, cfg_q.taper_voltage_mv};
      cps_pkg::RegFullCurrent:  prdata = {18'd0, cfg_q.full_current_ma};
      cps_pkg::RegFullVoltage:  prdata = {19'd0, cfg_q.full_voltage_mv};
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/cps_phase_logic.sv]
// ----------------------------------------------------------------------------
// cps_phase_logic
// Next-phase decision from the current phase, one tick and the thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_phase_logic (
  input  cps_pkg::phase_e phase_i,
  input  cps_pkg::tick_t  tick_i,
  input  cps_pkg::cfg_t   cfg_i,
  output cps_pkg::phase_e phase_o
);

  logic [14:0] ibat_abs;
  logic        cv_hit;
  logic        taper_hit;
  logic        full_hit;
  logic        thermal_off;

  // 15-bit magnitude; the most negative code maps to 16384
  assign ibat_abs = tick_i.battery_ma[14] ? (15'd0 - tick_i.battery_ma)
                                          : tick_i.battery_ma;

  assign cv_hit = (cfg_i.cv_voltage_mv != '0) &&
                  (tick_i.battery_mv >= cfg_i.cv_voltage_mv);

  assign taper_hit = ((cfg_i.taper_soc_pct != '0) &&
                      (tick_i.charge_level_pct >= cfg_i.taper_soc_pct)) ||
                     ((cfg_i.taper_voltage_mv != '0) &&
                      (tick_i.battery_mv >= cfg_i.taper_voltage_mv));

  assign full_hit = (cfg_i.full_current_ma != '0) && (cfg_i.full_voltage_mv != '0) &&
                    (ibat_abs <= {1'b0, cfg_i.full_current_ma}) &&
                    (tick_i.battery_mv >= cfg_i.full_voltage_mv);

  assign thermal_off = (tick_i.thermal_limit == '0) &&
                       (phase_i != cps_pkg::PhDepol) && (phase_i != cps_pkg::PhRestart);

  always_comb begin
    if (thermal_off) begin
      phase_o = cps_pkg::PhIdle;
    end else begin
      unique case (phase_i)
        cps_pkg::PhIdle:    phase_o = cps_pkg::PhRise;
        cps_pkg::PhRise:    phase_o = cv_hit ? cps_pkg::PhCv : cps_pkg::PhRise;
        cps_pkg::PhRestart: phase_o = cv_hit ? cps_pkg::PhCv : cps_pkg::PhRestart;
        cps_pkg::PhCv:      phase_o = taper_hit ? cps_pkg::PhTaper : cps_pkg::PhCv;
        cps_pkg::PhTaper: begin
          if (tick_i.commanded_ma <= cps_pkg::DepolCurrentMa) begin
            phase_o = cps_pkg::PhDepol;
          end else if (full_hit) begin
            phase_o = cps_pkg::PhFull;
          end else begin
            phase_o = cps_pkg::PhTaper;
          end
        end
        cps_pkg::PhDepol:   phase_o = cps_pkg::PhRestart;
        cps_pkg::PhFull:    phase_o = cps_pkg::PhFull;
        default:            phase_o = phase_i;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/charge_phase_sequencer_unit.sv]
// an accepted input item is held in the input register, then its phase in the phase register
// throughput: one item per cycle unless the output stalls; the phase register is the only feedback loop
// a stalled result lets the input register take one more item, then input stalls
// reset: phase goes to idle, thresholds clear to zero, both stages empty
// ----------------------------------------------------------------------------
// charge_phase_sequencer_unit
// CC/CV charge phase sequencer with stream ports and an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module charge_phase_sequencer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // battery_mv[12:0], battery_ma[27:13], charge_level_pct[34:28],
  // commanded_ma[48:35], thermal_limit[56:49], zero fill[63:57]
  input  wire logic [63:0]                    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // phase[2:0], zero fill[7:3]
  output logic [7:0]                          m_axis_tdata,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [cps_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [cps_pkg::DataWidth-1:0]  pwdata,
  output logic      [cps_pkg::DataWidth-1:0]  prdata,
  output logic                                pready
);

  cps_pkg::cfg_t   cfg;
  cps_pkg::tick_t  tick_q;
  logic            in_valid_q;
  logic            out_valid_q;
  cps_pkg::phase_e phase_q, phase_d;
  logic            advance;

  cps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cps_phase_logic u_logic (
    .phase_i (phase_q),
    .tick_i  (tick_q),
    .cfg_i   (cfg),
    .phase_o (phase_d)
  );

  // the held item moves on when the output slot is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= cps_pkg::PhIdle;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick_q <= s_axis_tdata[56:0];
    end
  end

  // phase register doubles as the output data; it only changes on advance
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, phase_q};

endmodule

`default_nettype wire

[hdl/cps_checker.sv]
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks of the charge phase sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // the unused phase code never shows and the fill stays zero
  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) && (m_axis_tdata[7:3] == 5'd0))
    else $error("bad phase code on output");

  // an accepted item is followed by a valid result once it has passed the input and phase registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted item gave no result");

  // with the output drained the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind charge_phase_sequencer_unit cps_checker u_cps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire

[tb/charge_phase_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charge_phase_sequencer_unit_tb
// Drives control ticks into the charge phase sequencer, tracks the charge
// phase alongside it, checks every phase it returns and reads back the thresholds.
// ----------------------------------------------------------------------------

module charge_phase_sequencer_unit_tb;

  localparam int RegCount  = 5;
  localparam int RegSlots  = 8;
  localparam int LongHold  = 300;
  localparam int Segments  = 6;
  localparam int SegTicks  = 250;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [63:0]                   s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [cps_pkg::AddrWidth-1:0] paddr         = '0;
  logic [cps_pkg::DataWidth-1:0] pwdata        = '0;
  logic [cps_pkg::DataWidth-1:0] prdata;
  logic                          pready;

  // threshold settings per segment: cv, taper soc, taper mv, full ma, full mv
  logic [31:0] seg_cfg [0:Segments*RegCount-1] = '{
    32'd4000, 32'd80, 32'd4300, 32'd200, 32'd4200,
    32'd8191, 32'd100, 32'd8191, 32'd16383, 32'd8191,
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
    32'd3000, 32'd0, 32'd3600, 32'd0, 32'd3500,
    32'd3700, 32'd50, 32'd0, 32'd500, 32'd4100,
    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff
  };

  cps_pkg::cfg_t   thresholds = '0;
  cps_pkg::phase_e phase_now  = cps_pkg::PhIdle;
  cps_pkg::tick_t  pending_ticks[$];
  cps_pkg::phase_e expected_phases[$];
  int     error_count    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  logic   long_hold_arm  = 1'b0;
  int     hold_cycles    = 0;

  charge_phase_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic cps_pkg::phase_e advance_phase(cps_pkg::phase_e cur,
                                                    cps_pkg::tick_t t);
    logic [15:0] magnitude;
    logic        cv_reached;
    magnitude  = t.battery_ma[14] ? 16'h8000 - {1'b0, t.battery_ma}
                                  : {1'b0, t.battery_ma};
    cv_reached = thresholds.cv_voltage_mv != 0 && t.battery_mv >= thresholds.cv_voltage_mv;
    // a hot or inactive charger drops to idle, but the depolarize and restart phases run on
    if (t.thermal_limit == 0 && cur != cps_pkg::PhDepol && cur != cps_pkg::PhRestart)
      return cps_pkg::PhIdle;
    case (cur)
      cps_pkg::PhIdle:    return cps_pkg::PhRise;
      cps_pkg::PhRise:    return cv_reached ? cps_pkg::PhCv : cps_pkg::PhRise;
      cps_pkg::PhRestart: return cv_reached ? cps_pkg::PhCv : cps_pkg::PhRestart;
      cps_pkg::PhCv: begin
        if (thresholds.taper_soc_pct != 0 && t.charge_level_pct >= thresholds.taper_soc_pct)
          return cps_pkg::PhTaper;
        if (thresholds.taper_voltage_mv != 0 && t.battery_mv >= thresholds.taper_voltage_mv)
          return cps_pkg::PhTaper;
        return cps_pkg::PhCv;
      end
      cps_pkg::PhTaper: begin
        if (t.commanded_ma <= cps_pkg::DepolCurrentMa) return cps_pkg::PhDepol;
        if (thresholds.full_current_ma != 0 && thresholds.full_voltage_mv != 0 &&
            magnitude <= thresholds.full_current_ma &&
            t.battery_mv >= thresholds.full_voltage_mv)
          return cps_pkg::PhFull;
        return cps_pkg::PhTaper;
      end
      cps_pkg::PhDepol:   return cps_pkg::PhRestart;
      cps_pkg::PhFull:    return cps_pkg::PhFull;
      default:            return cur;
    endcase
  endfunction

  function automatic int near(int center, int spread, int top);
    int v;
    v = center + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic cps_pkg::tick_t make_tick(int mv, int ma, int soc, int cmd,
                                               int thermal);
    cps_pkg::tick_t t;
    t.battery_mv       = 13'(mv);
    t.battery_ma       = 15'(ma);
    t.charge_level_pct = 7'(soc);
    t.commanded_ma     = 14'(cmd);
    t.thermal_limit    = 8'(thermal);
    return t;
  endfunction

  // values cluster around the active thresholds so the phases keep moving
  function automatic cps_pkg::tick_t random_tick();
    int mv;
    int mag;
    int ma;
    int soc;
    int cmd;
    int thermal;
    case ($urandom_range(0, 3))
      0:       mv = near(thresholds.cv_voltage_mv, 24, 8191);
      1:       mv = near(thresholds.taper_voltage_mv, 24, 8191);
      2:       mv = near(thresholds.full_voltage_mv, 24, 8191);
      default: mv = $urandom_range(0, 8191);
    endcase
    if ($urandom_range(0, 3) == 0) mag = $urandom_range(0, 16384);
    else mag = near(thresholds.full_current_ma, 4, 16384);
    if ($urandom_range(0, 1) == 0) ma = -mag;
    else ma = (mag > 16383) ? 16383 : mag;
    if ($urandom_range(0, 3) == 0) soc = $urandom_range(0, 127);
    else soc = near(thresholds.taper_soc_pct, 3, 127);
    case ($urandom_range(0, 4))
      0:       cmd = $urandom_range(0, 120);
      1:       cmd = $urandom_range(0, 16383);
      default: cmd = $urandom_range(101, 16383);
    endcase
    thermal = ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(1, 255);
    return make_tick(mv, ma, soc, cmd, thermal);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      cps_pkg::RegCvVoltage:    thresholds.cv_voltage_mv    = value[12:0];
      cps_pkg::RegTaperSoc:     thresholds.taper_soc_pct    = value[6:0];
      cps_pkg::RegTaperVoltage: thresholds.taper_voltage_mv = value[12:0];
      cps_pkg::RegFullCurrent:  thresholds.full_current_ma  = value[13:0];
      cps_pkg::RegFullVoltage:  thresholds.full_voltage_mv  = value[12:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_regs();
    logic [31:0] want;
    for (int r = 0; r < RegCount; r++) begin
      case (r[2:0])
        cps_pkg::RegCvVoltage:    want = 32'(thresholds.cv_voltage_mv);
        cps_pkg::RegTaperSoc:     want = 32'(thresholds.taper_soc_pct);
        cps_pkg::RegTaperVoltage: want = 32'(thresholds.taper_voltage_mv);
        cps_pkg::RegFullCurrent:  want = 32'(thresholds.full_current_ma);
        default:                  want = 32'(thresholds.full_voltage_mv);
      endcase
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r[2:0], 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== want) begin
        $error("prdata[%0d]: expected %0d, got %0d", r, want, prdata);
        error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_until_drained();
    while (pending_ticks.size() != 0 || s_axis_tvalid || expected_phases.size() != 0)
      @(negedge clk_i);
  endtask

  // sender: offers queued ticks, predicts the phase of each accepted one
  always @(posedge clk_i) begin : drive_proc
    cps_pkg::tick_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        got       = s_axis_tdata[$bits(cps_pkg::tick_t)-1:0];
        phase_now = advance_phase(phase_now, got);
        expected_phases.push_back(phase_now);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata  <= {7'd0, pending_ticks.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each phase item, stalls at random or for one long stretch
  always @(posedge clk_i) begin : accept_proc
    cps_pkg::phase_e want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_phases.size() == 0) begin
          $error("phase: unexpected item, got %0d", m_axis_tdata[2:0]);
          error_count++;
        end else begin
          want = expected_phases.pop_front();
          if (m_axis_tdata[2:0] !== want) begin
            $error("phase: expected %0d, got %0d", want, m_axis_tdata[2:0]);
            error_count++;
          end
          if (m_axis_tdata[7:3] !== 5'd0) begin
            $error("zero_fill: expected 0, got %0d", m_axis_tdata[7:3]);
            error_count++;
          end
        end
      end
      if (long_hold_arm && hold_cycles < LongHold) begin
        m_axis_tready <= 1'b0;
        hold_cycles++;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    verify_regs();

    // thresholds still cleared: rise can never reach cv
    pending_ticks.push_back(make_tick(0, 0, 0, 0, 7));
    pending_ticks.push_back(make_tick(8191, -1, 100, 16383, 255));
    pending_ticks.push_back(make_tick(8191, 0, 0, 0, 0));
    wait_until_drained();

    for (int seg = 0; seg < Segments; seg++) begin
      if (seg < 2) begin
        send_idle_pct  = 8;
        recv_stall_pct = 47;
      end else if (seg < 4) begin
        send_idle_pct  = 47;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (int r = 0; r < RegCount; r++) reg_write(r[2:0], seg_cfg[seg * RegCount + r]);
      if (seg == 1) begin
        // unmapped addresses must leave the thresholds alone
        for (int r = RegCount; r < RegSlots; r++) reg_write(r[2:0], 32'hffff_ffff);
      end
      verify_regs();

      if (seg == 0) begin
        // walk every phase with cv 4000, soc 80, taper 4300, full 200 / 4200
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(3999, 0, 0, 16383, 255));
        pending_ticks.push_back(make_tick(3999, 16383, 100, 500, 1));
        pending_ticks.push_back(make_tick(4000, -1, 0, 500, 9));
        pending_ticks.push_back(make_tick(4299, 0, 79, 500, 9));
        pending_ticks.push_back(make_tick(0, 0, 80, 500, 9));
        pending_ticks.push_back(make_tick(4200, -201, 0, 101, 9));
        pending_ticks.push_back(make_tick(8191, -16384, 0, 101, 9));
        pending_ticks.push_back(make_tick(4199, -200, 0, 16383, 9));
        pending_ticks.push_back(make_tick(4200, 200, 0, 500, 9));
        pending_ticks.push_back(make_tick(0, 16383, 127, 0, 1));
        pending_ticks.push_back(make_tick(8191, 0, 0, 500, 0));
        pending_ticks.push_back(make_tick(0, 0, 0, 500, 128));
        pending_ticks.push_back(make_tick(8191, 0, 0, 500, 128));
        pending_ticks.push_back(make_tick(4300, 0, 0, 500, 128));
        pending_ticks.push_back(make_tick(0, 0, 0, 100, 128));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(3999, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(3999, 0, 0, 0, 200));
        pending_ticks.push_back(make_tick(4000, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, 0, 127, 0, 0));
        pending_ticks.push_back(make_tick(0, 0, 0, 0, 255));
        wait_until_drained();
      end

      for (int i = 0; i < SegTicks; i++) begin
        pending_ticks.push_back(random_tick());
        // sender holds back until the block has returned everything
        if (seg == 2 && i == SegTicks / 2) wait_until_drained();
      end
      // long receiver stall while the sender keeps offering
      if (seg == 1) long_hold_arm = 1'b1;
      wait_until_drained();
    end

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/cps_pkg.sv
hdl/cps_cfg_regs.sv
hdl/cps_phase_logic.sv
hdl/charge_phase_sequencer_unit.sv
hdl/cps_checker.sv
tb/charge_phase_sequencer_unit_tb.sv
